// File: rtl/core/face_owner_neighbour_table_top_assert.svh
// Assertion macros for the face owner/neighbour table.
`ifndef FACE_OWNER_NEIGHBOUR_TABLE_TOP_ASSERT_SVH
`define FACE_OWNER_NEIGHBOUR_TABLE_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define FONT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FONT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FONT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define FONT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/fontab_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package fontab_pkg;

  localparam int MAX_FACES   = 65536;
  localparam int MAX_CELLS   = 65536;
  localparam int FACE_AW     = $clog2(MAX_FACES);
  localparam int IDX_W       = 16;
  localparam int CELL_W      = 17;
  localparam int CNT_W       = 17;
  localparam int WORD_W      = 2 * CELL_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * CELL_W - CNT_W;

  localparam logic [CELL_W-1:0] EMPTY_CELL = {CELL_W{1'b1}};
  localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_OWNER     = 2'd0,
    ST_NEIGHBOUR = 2'd1,
    ST_CONFLICT  = 2'd2,
    ST_READ      = 2'd3
  } status_t;

  typedef struct packed {
    logic clr;     // write one empty entry of the clearing pass
    logic accept;  // input transfer: capture item, read table
    logic exec;    // update entry, load result register
  } cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing pass at last entry
    logic out_free;  // result register may be loaded this cycle
  } sts_t;

endpackage

// File: rtl/core/fontab_ctrl.sv
// Controller state machine: clearing pass, item accept, table update.
module fontab_ctrl
  import fontab_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_RMW   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RMW;
        end
      end
      S_RMW: begin
        // hold the read word until the result register has room
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/core/fontab_dp.sv
// Datapath: face table memory, update logic, counter and result register.
module fontab_dp
  import fontab_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] face_index, [31:16] cell_index
  input  logic                   in_tuser,   // [0] opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // owner_cell, neighbour_cell, internal_faces
  output logic [1:0]             out_tuser   // [1:0] status
);

  // neighbour in upper half, owner in lower half
  logic [WORD_W-1:0]  mem [MAX_FACES];
  logic [WORD_W-1:0]  rd_word_r;
  logic [FACE_AW-1:0] clr_cnt_r;

  logic               op_r;
  logic [IDX_W-1:0]   face_r;
  logic [IDX_W-1:0]   cell_r;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r;
  logic [CELL_W-1:0]  out_own_r, out_nei_r;
  logic [CNT_W-1:0]   out_cnt_r;
  status_t            out_st_r;

  logic               face_ok, cell_ok;
  logic [CELL_W-1:0]  cur_own, cur_nei, c17;
  logic [CELL_W-1:0]  new_own, new_nei;
  status_t            new_st;
  logic               do_write, do_inc;
  logic               wr_en;
  logic [FACE_AW-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;

  assign face_ok = 32'(face_r) < 32'(MAX_FACES);
  assign cell_ok = 32'(cell_r) < 32'(MAX_CELLS);
  assign cur_own = rd_word_r[CELL_W-1:0];
  assign cur_nei = rd_word_r[WORD_W-1:CELL_W];
  assign c17     = {1'b0, cell_r};

  always_comb begin
    new_own  = cur_own;
    new_nei  = cur_nei;
    new_st   = ST_CONFLICT;
    do_write = 1'b0;
    do_inc   = 1'b0;
    priority if (!face_ok) begin
      new_own = EMPTY_CELL;
      new_nei = EMPTY_CELL;
      new_st  = (op_r == OP_READ) ? ST_READ : ST_CONFLICT;
    end else if (op_r == OP_READ) begin
      new_st = ST_READ;
    end else if (!cell_ok) begin
      new_st = ST_CONFLICT;
    end else if (cur_own == EMPTY_CELL) begin
      new_own  = c17;
      new_st   = ST_OWNER;
      do_write = 1'b1;
    end else if (cur_nei == EMPTY_CELL) begin
      if ($signed(cur_own) > $signed(c17)) begin
        new_own = c17;
        new_nei = cur_own;
      end else begin
        new_nei = c17;
      end
      new_st   = ST_NEIGHBOUR;
      do_write = 1'b1;
      do_inc   = 1'b1;
    end else begin
      new_st = ST_CONFLICT;
    end
  end

  // saturating internal-face count
  assign cnt_nxt = (do_inc && cnt_r != COUNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;

  assign wr_en   = cmd.clr || (cmd.exec && do_write);
  assign wr_addr = cmd.clr ? clr_cnt_r : face_r[FACE_AW-1:0];
  assign wr_data = cmd.clr ? {EMPTY_CELL, EMPTY_CELL} : {new_nei, new_own};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_word_r <= mem[in_tdata[FACE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_tuser;
      face_r <= in_tdata[IDX_W-1:0];
      cell_r <= in_tdata[2*IDX_W-1:IDX_W];
    end
    if (cmd.exec) begin
      out_own_r <= new_own;
      out_nei_r <= new_nei;
      out_cnt_r <= cnt_nxt;
      out_st_r  <= new_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + FACE_AW'(1);
      end
      if (cmd.exec) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clr_last = (clr_cnt_r == FACE_AW'(MAX_FACES - 1));
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_r, out_nei_r, out_own_r};
  assign out_tuser  = out_st_r;

endmodule

// File: rtl/core/face_owner_neighbour_table_top.sv
// Top level of the face owner/neighbour table.
// Result path: the transfer registers the table read word; the update, held until the result
// register has room, writes the table and loads the result. One item is in flight at a time.
// Reset: synchronous, active low; then a clearing pass (one entry a cycle) empties all 65536
//   face entries, with in_tready low throughout.
`include "face_owner_neighbour_table_top_assert.svh"

module face_owner_neighbour_table_top
  import fontab_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] face_index, [31:16] cell_index
  input  logic                   in_tuser,   // [0] opcode: record / read
  // result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [16:0] owner_cell, [33:17] neighbour_cell,
                                             // [50:34] internal_faces, [55:51] zero
  output logic [1:0]             out_tuser   // [1:0] status
);

  // Controller steps through clear / idle / read-modify-write; datapath holds the
  // table (one memory word per face: owner and neighbour), the running count and
  // the result register. The result register lets the next item be taken while
  // a finished result still waits for its transfer.
  cmd_t cmd;
  sts_t sts;

  fontab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fontab_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // one item in flight: after a transfer the input side closes for the update
  `FONT_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "second item taken during update")
  // update only when the result register can take it
  `FONT_ASSERT_IMP(a_exec_room, clk, rst_n, cmd.exec, sts.out_free, "result register overwritten")
  // a new result appears only from an update
  `FONT_ASSERT_IMP(a_valid_source, clk, rst_n, $rose(out_tvalid), $past(cmd.exec), "result without update")
  // no input transfer while the clearing pass runs
  `FONT_ASSERT_IMP(a_clear_closed, clk, rst_n, cmd.clr, !in_tready && !cmd.exec, "input taken during clear")

endmodule
